// File: design/hdm_pkg.sv
package hdm_pkg;

	localparam int unsigned CHANNELS_DEF = 6;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned DEADLINE_W = 16;
	localparam int unsigned SNAP_W = 16;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [DEADLINE_W-1:0] FAST_DEADLINE_RST = 16'd500;
	localparam logic [DEADLINE_W-1:0] SLOW_DEADLINE_RST = 16'd2500;
	localparam logic [TIME_W-1:0] REARM_DELAY_RST = 32'd30000;
	localparam logic [15:0] SLOW_SELECT_RST = 16'd12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAST_DEADLINE = 2'd0,
		REG_SLOW_DEADLINE = 2'd1,
		REG_REARM_DELAY   = 2'd2,
		REG_SLOW_SELECT   = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ACT_MARK  = 1'b0,
		ACT_CHECK = 1'b1
	} action_t;

endpackage

// File: design/heartbeat_deadline_monitor_top.sv
// An input transfer passes the input register, then the result register; one item per cycle
// unless out_ready stalls, and the next item sees the state left by the previous one.
// Per-channel elapsed-time compares and the fault latch update sit between the two registers.
// Reset (arst_n low, asynchronous): stamps, healthy start, reported mask, fault latch and
// captured mask clear to zero; configuration returns to its default values.
module heartbeat_deadline_monitor_top
	import hdm_pkg::*;
#(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,

	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   action,
	input  logic [TIME_W-1:0]      now_ms,
	input  logic [CHANNELS-1:0]    channel_select,
	input  logic [SNAP_W-1:0]      status_word,

	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   healthy,
	output logic [CHANNELS-1:0]    late_mask,
	output logic                   report_change,
	output logic                   save_request,
	output logic [SNAP_W-1:0]      saved_snapshot,
	output logic                   latched,
	output logic [CHANNELS-1:0]    kept_unhealthy_mask
);

	// configuration
	logic [DEADLINE_W-1:0] fast_deadline_q;
	logic [DEADLINE_W-1:0] slow_deadline_q;
	logic [TIME_W-1:0]     rearm_delay_q;
	logic [CHANNELS-1:0]   slow_select_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_deadline_q <= FAST_DEADLINE_RST;
			slow_deadline_q <= SLOW_DEADLINE_RST;
			rearm_delay_q   <= REARM_DELAY_RST;
			slow_select_q   <= SLOW_SELECT_RST[CHANNELS-1:0];
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FAST_DEADLINE: fast_deadline_q <= cfg_data[DEADLINE_W-1:0];
				REG_SLOW_DEADLINE: slow_deadline_q <= cfg_data[DEADLINE_W-1:0];
				REG_REARM_DELAY:   rearm_delay_q   <= cfg_data[TIME_W-1:0];
				REG_SLOW_SELECT:   slow_select_q   <= cfg_data[CHANNELS-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic                  valid_s1;
	logic                  action_s1;
	logic [TIME_W-1:0]     now_s1;
	logic [CHANNELS-1:0]   sel_s1;
	logic [SNAP_W-1:0]     snap_s1;
	logic                  adv_s1;

	assign adv_s1   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			now_s1    <= now_ms;
			sel_s1    <= channel_select;
			snap_s1   <= status_word;
		end
	end

	// monitor state
	logic [TIME_W-1:0]   last_seen_q [CHANNELS];
	logic [TIME_W-1:0]   healthy_start_q;
	logic [CHANNELS-1:0] reported_late_q;
	logic                fault_q;
	logic [CHANNELS-1:0] captured_q;

	// single-pass evaluation
	logic [CHANNELS-1:0] late_c;
	logic [TIME_W-1:0]   elapsed_c [CHANNELS];
	logic [TIME_W-1:0]   rearm_elapsed_c;
	logic                is_check_c;
	logic                any_late_c;
	logic                change_c;
	logic                save_c;
	logic                fault_d;
	logic [CHANNELS-1:0] captured_d;
	logic [CHANNELS-1:0] reported_d;
	logic [TIME_W-1:0]   healthy_start_d;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			elapsed_c[i] = now_s1 - last_seen_q[i];
			late_c[i]    = 1'b0;
			if (slow_select_q[i]) begin
				late_c[i] = elapsed_c[i] > {{(TIME_W-DEADLINE_W){1'b0}}, slow_deadline_q};
			end else begin
				late_c[i] = elapsed_c[i] > {{(TIME_W-DEADLINE_W){1'b0}}, fast_deadline_q};
			end
		end
	end

	assign is_check_c      = (action_t'(action_s1) == ACT_CHECK);
	assign any_late_c      = is_check_c && (late_c != '0);
	assign rearm_elapsed_c = now_s1 - healthy_start_q;

	always_comb begin
		change_c        = 1'b0;
		save_c          = 1'b0;
		fault_d         = fault_q;
		captured_d      = captured_q;
		reported_d      = reported_late_q;
		healthy_start_d = healthy_start_q;
		if (is_check_c) begin
			if (any_late_c) begin
				healthy_start_d = '0;
				if (late_c != reported_late_q) begin
					change_c   = 1'b1;
					reported_d = late_c;
				end
				if (!fault_q) begin
					captured_d = late_c;
					save_c     = 1'b1;
					fault_d    = 1'b1;
				end
			end else begin
				reported_d = '0;
				if (fault_q) begin
					priority if (healthy_start_q == '0) begin
						healthy_start_d = now_s1;
					end else if (rearm_elapsed_c >= rearm_delay_q) begin
						fault_d         = 1'b0;
						healthy_start_d = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_seen_q[i] <= '0;
			end
			healthy_start_q <= '0;
			reported_late_q <= '0;
			fault_q         <= 1'b0;
			captured_q      <= '0;
		end else if (adv_s1) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (!is_check_c && sel_s1[i]) begin
					last_seen_q[i] <= now_s1;
				end
			end
			healthy_start_q <= healthy_start_d;
			reported_late_q <= reported_d;
			fault_q         <= fault_d;
			captured_q      <= captured_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			healthy             <= !any_late_c;
			late_mask           <= is_check_c ? late_c : '0;
			report_change       <= change_c;
			save_request        <= save_c;
			saved_snapshot      <= save_c ? snap_s1 : '0;
			latched             <= fault_d;
			kept_unhealthy_mask <= captured_d;
		end
	end

endmodule

// File: tb/tb_heartbeat_deadline_monitor_top.sv
`timescale 1ns / 1ps

module tb_heartbeat_deadline_monitor_top
	import hdm_pkg::*;
();

	localparam int NCH = CHANNELS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 4;

	typedef struct packed {
		logic            healthy;
		logic [NCH-1:0]  late;
		logic            change;
		logic            save;
		logic [15:0]     saved;
		logic            latched;
		logic [NCH-1:0]  kept;
	} beat_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  action = 1'b0;
	logic [TIME_W-1:0]     now_ms = '0;
	logic [NCH-1:0]        channel_select = '0;
	logic [SNAP_W-1:0]     status_word = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  healthy;
	logic [NCH-1:0]        late_mask;
	logic                  report_change;
	logic                  save_request;
	logic [SNAP_W-1:0]     saved_snapshot;
	logic                  latched;
	logic [NCH-1:0]        kept_unhealthy_mask;

	heartbeat_deadline_monitor_top dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.action              (action),
		.now_ms              (now_ms),
		.channel_select      (channel_select),
		.status_word         (status_word),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.healthy             (healthy),
		.late_mask           (late_mask),
		.report_change       (report_change),
		.save_request        (save_request),
		.saved_snapshot      (saved_snapshot),
		.latched             (latched),
		.kept_unhealthy_mask (kept_unhealthy_mask)
	);

	// predictor state and shadow configuration
	logic [15:0]    fast_dl = FAST_DEADLINE_RST;
	logic [15:0]    slow_dl = SLOW_DEADLINE_RST;
	logic [31:0]    rearm_ms = REARM_DELAY_RST;
	logic [NCH-1:0] slow_sel = SLOW_SELECT_RST[NCH-1:0];
	logic [31:0]    last_seen [NCH];
	logic [31:0]    healthy_since = '0;
	logic [NCH-1:0] last_report = '0;
	logic           fault_latch = 1'b0;
	logic [NCH-1:0] captured = '0;

	beat_result_t expected_q [$];

	int errors = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int n_marks = 0;
	int n_checks = 0;
	int n_results = 0;
	int n_latches = 0;
	int n_rearms = 0;
	int n_phases = 0;
	logic [31:0] clock_ms = '0;

	initial begin
		for (int i = 0; i < NCH; i++)
			last_seen[i] = '0;
	end

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= stall_pct);

	function automatic beat_result_t predict_beat(action_t act, logic [31:0] now,
			logic [NCH-1:0] sel, logic [15:0] snap);
		beat_result_t r;
		logic [31:0] elapsed;
		logic [15:0] limit;
		r = '0;
		r.healthy = 1'b1;
		if (act == ACT_MARK) begin
			for (int i = 0; i < NCH; i++)
				if (sel[i])
					last_seen[i] = now;
		end else begin
			for (int i = 0; i < NCH; i++) begin
				limit = slow_sel[i] ? slow_dl : fast_dl;
				elapsed = now - last_seen[i];
				if (elapsed > {16'd0, limit})
					r.late[i] = 1'b1;
			end
			if (r.late != '0) begin
				r.healthy = 1'b0;
				healthy_since = '0;
				if (r.late != last_report) begin
					r.change = 1'b1;
					last_report = r.late;
				end
				if (!fault_latch) begin
					captured = r.late;
					r.save = 1'b1;
					r.saved = snap;
					fault_latch = 1'b1;
					n_latches++;
				end
			end else begin
				last_report = '0;
				if (fault_latch) begin
					// a start stamp of zero reads as not started
					if (healthy_since == '0) begin
						healthy_since = now;
					end else if (32'(now - healthy_since) >= rearm_ms) begin
						fault_latch = 1'b0;
						healthy_since = '0;
						n_rearms++;
					end
				end
			end
		end
		r.latched = fault_latch;
		r.kept = captured;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (exp !== act) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		beat_result_t exp;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				exp = expected_q.pop_front();
				check_field("healthy", 32'(exp.healthy), 32'(healthy));
				check_field("late_mask", 32'(exp.late), 32'(late_mask));
				check_field("report_change", 32'(exp.change), 32'(report_change));
				check_field("save_request", 32'(exp.save), 32'(save_request));
				check_field("saved_snapshot", 32'(exp.saved), 32'(saved_snapshot));
				check_field("latched", 32'(exp.latched), 32'(latched));
				check_field("kept_unhealthy_mask", 32'(exp.kept),
					32'(kept_unhealthy_mask));
			end
		end
	end

	task automatic send_beat(action_t act, logic [31:0] now, logic [NCH-1:0] sel,
			logic [15:0] snap);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		now_ms <= now;
		channel_select <= sel;
		status_word <= snap;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(predict_beat(act, now, sel, snap));
		if (act == ACT_MARK)
			n_marks++;
		else
			n_checks++;
	endtask

	// stop sending and let every outstanding transfer come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_config(logic [31:0] fast_word, logic [31:0] slow_word,
			logic [31:0] rearm_word, logic [31:0] sel_word);
		wait_idle();
		write_reg(REG_FAST_DEADLINE, fast_word);
		write_reg(REG_SLOW_DEADLINE, slow_word);
		write_reg(REG_REARM_DELAY, rearm_word);
		write_reg(REG_SLOW_SELECT, sel_word);
		cfg_valid <= 1'b0;
		fast_dl = fast_word[15:0];
		slow_dl = slow_word[15:0];
		rearm_ms = rearm_word;
		slow_sel = sel_word[NCH-1:0];
		n_phases++;
	endtask

	task automatic test_reset_defaults();
		send_beat(ACT_CHECK, 32'd0, 6'h3F, 16'h0000);
		send_beat(ACT_CHECK, 32'd500, 6'h00, 16'h0001);
		send_beat(ACT_CHECK, 32'd501, 6'h00, 16'hFFFF);
		send_beat(ACT_CHECK, 32'd501, 6'h00, 16'h1234);
		send_beat(ACT_CHECK, 32'd2501, 6'h00, 16'h5678);
		send_beat(ACT_MARK, 32'd2501, 6'h3F, 16'hFFFF);
		send_beat(ACT_CHECK, 32'd2501, 6'h00, 16'h0000);
		send_beat(ACT_CHECK, 32'd2502, 6'h00, 16'h0000);
		// late again while latched: no fresh save, healthy interval restarts
		send_beat(ACT_MARK, 32'd3000, 6'h15, 16'h0000);
		send_beat(ACT_CHECK, 32'd3200, 6'h00, 16'hAAAA);
	endtask

	task automatic test_zero_settings();
		apply_config(32'hFFFF_0000, 32'h0001_0000, 32'd0, 32'hFFFF_FFC0);
		// healthy at time zero does not start the interval
		send_beat(ACT_MARK, 32'd0, 6'h3F, 16'h0000);
		send_beat(ACT_CHECK, 32'd0, 6'h00, 16'h0000);
		send_beat(ACT_CHECK, 32'd0, 6'h00, 16'h0000);
		send_beat(ACT_MARK, 32'd1, 6'h3F, 16'h0000);
		send_beat(ACT_CHECK, 32'd1, 6'h00, 16'h0000);
		send_beat(ACT_CHECK, 32'd1, 6'h00, 16'h0000);
		send_beat(ACT_CHECK, 32'd2, 6'h00, 16'h5555);
	endtask

	task automatic test_wrap_extremes();
		apply_config(32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_002A);
		send_beat(ACT_MARK, 32'hFFFF_FFF0, 6'h3F, 16'h0000);
		send_beat(ACT_CHECK, 32'h0000_FFEF, 6'h3F, 16'h0000);
		send_beat(ACT_MARK, 32'hFFFF_FFFF, 6'h00, 16'hFFFF);
		send_beat(ACT_CHECK, 32'h0000_FFF0, 6'h00, 16'hC3C3);
	endtask

	task automatic run_random_phase(int items, int i_pct, int s_pct, bit hold_mid);
		int r;
		int step_max;
		logic [31:0] now;
		action_t act;
		logic [NCH-1:0] sel;
		idle_pct = i_pct;
		stall_pct = s_pct;
		step_max = ((fast_dl > slow_dl) ? fast_dl : slow_dl) / 2 + 2;
		for (int n = 0; n < items; n++) begin
			if (hold_mid && n == items / 2)
				wait_idle();
			r = $urandom_range(0, 99);
			if (r < 4)
				now = 32'd0;
			else if (r < 8)
				now = 32'hFFFF_FFFF;
			else if (r < 16)
				now = $urandom();
			else
				now = clock_ms + $urandom_range(0, step_max);
			clock_ms = now;
			act = ($urandom_range(0, 99) < 45) ? ACT_CHECK : ACT_MARK;
			sel = ($urandom_range(0, 3) == 0) ? 6'h3F : 6'($urandom_range(0, 63));
			send_beat(act, now, sel, 16'($urandom_range(0, 65535)));
		end
		stall_pct = 0;
		idle_pct = 0;
	endtask

	task automatic test_random_phases();
		apply_config(32'd500, 32'd2500, 32'd2000, $urandom());
		run_random_phase(76, 0, 0, 1'b0);
		apply_config($urandom(), $urandom(), $urandom_range(0, 3000), $urandom());
		run_random_phase(76, 60, 0, 1'b1);
		apply_config(32'h0000_FFFF, 32'd0, 32'd0, $urandom());
		run_random_phase(76, 0, 60, 1'b0);
		apply_config(32'd0, 32'h0000_FFFF, 32'hFFFF_FFFF, $urandom());
		run_random_phase(76, 10, 10, 1'b0);
		apply_config({16'($urandom_range(0, 65535)), 16'($urandom_range(1, 1500))},
			{16'($urandom_range(0, 65535)), 16'($urandom_range(1, 4000))},
			$urandom_range(0, 5000), $urandom());
		run_random_phase(76, 0, 0, 1'b0);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_zero_settings();
		test_wrap_extremes();
		test_random_phases();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("run: %0d marks and %0d checks over %0d register settings, %0d results",
			n_marks, n_checks, n_phases + 1, n_results);
		$display("run: fault latch set %0d times and rearmed %0d times", n_latches, n_rearms);
		if (errors == 0 && expected_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
